@@ design/tmv_pkg.sv @@
package tmv_pkg;

  localparam int DEFAULT_MAX_SIZE = 64;
  localparam int DATA_W           = 32;
  localparam int INDEX_W          = 6;
  localparam int CFG_W            = 7;
  localparam int RESET_SIZE       = 64;

  typedef enum logic {
    ST_ACCUM,
    ST_DUMP
  } tmv_state_t;

  // Control handed from the sequencer to the row of accumulator cells.
  typedef struct packed {
    logic shift;     // every cell takes its neighbour's value; the tail takes the wrap value
    logic clear;     // every cell returns to zero
    logic dump;      // the ring is being drained: the tail refills with zero
    logic load_out;  // the head cell's value goes to the output register
    logic last_out;  // the value being loaded is the final column
  } tmv_ring_ctl_t;

endpackage

@@ design/tmv_cell.sv @@
module tmv_cell
  import tmv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  tmv_ring_ctl_t     ctl,
  input  logic              is_tail,
  input  logic [DATA_W-1:0] from_next,
  input  logic [DATA_W-1:0] wrap_in,
  output logic [DATA_W-1:0] acc
);

  logic [DATA_W-1:0] acc_next;

  always_comb begin
    acc_next = acc;
    if (ctl.shift) begin
      acc_next = is_tail ? wrap_in : from_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

endmodule

@@ design/tmv_ctrl.sv @@
module tmv_ctrl
  import tmv_pkg::*;
#(
  parameter int MAX_SIZE = DEFAULT_MAX_SIZE,
  parameter int SIZE_W   = $clog2(MAX_SIZE + 1),
  parameter int IDX_W    = $clog2(MAX_SIZE)
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_fire,
  input  logic [SIZE_W-1:0] size,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output tmv_ring_ctl_t     ctl,
  output logic [IDX_W-1:0]  dump_idx
);

  tmv_state_t       state;
  tmv_state_t       state_next;
  logic [IDX_W-1:0] col_cnt;
  logic [IDX_W-1:0] row_cnt;
  logic             prod_valid;
  logic             prod_last;
  logic [IDX_W-1:0] size_top;
  logic             last_col;
  logic             last_row;
  logic             in_fire;
  logic             dump_end;

  assign size_top = IDX_W'(size - SIZE_W'(1));
  assign last_col = (col_cnt == size_top);
  assign last_row = (row_cnt == size_top);
  assign in_fire  = in_valid && in_ready;
  assign dump_end = ctl.load_out && (dump_idx == size_top);

  always_comb begin
    state_next = state;
    case (state)
      ST_ACCUM: begin
        if (prod_valid && prod_last) begin
          state_next = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (dump_end) begin
          state_next = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  // Input is held off while the final product of a matrix is still being added,
  // so that the drain starts from a settled ring.
  always_comb begin
    in_ready     = 1'b0;
    ctl.shift    = 1'b0;
    ctl.dump     = 1'b0;
    ctl.load_out = 1'b0;
    ctl.clear    = cfg_fire;
    ctl.last_out = (dump_idx == size_top);
    case (state)
      ST_ACCUM: begin
        in_ready  = !(prod_valid && prod_last);
        ctl.shift = prod_valid;
      end
      ST_DUMP: begin
        ctl.dump     = 1'b1;
        ctl.load_out = !out_valid || out_ready;
        ctl.shift    = ctl.load_out;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      state      <= ST_ACCUM;
      col_cnt    <= '0;
      row_cnt    <= '0;
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
      dump_idx   <= '0;
    end else begin
      state      <= state_next;
      prod_valid <= in_fire;
      prod_last  <= in_fire && last_col && last_row;
      if (in_fire) begin
        col_cnt <= last_col ? '0 : col_cnt + IDX_W'(1);
        if (last_col) begin
          row_cnt <= last_row ? '0 : row_cnt + IDX_W'(1);
        end
      end
      if (ctl.load_out) begin
        dump_idx <= dump_end ? '0 : dump_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ design/transposed_matrix_vector_multiply.sv @@
// Column inner products of a square matrix with a vector (A transposed times x).
// Input channel (in_valid/in_ready): one transfer per matrix element, row-major,
// carrying the element and the vector element of its row. Input is accepted at
// one transfer per clock cycle while a matrix streams in.
// Output channel (out_valid/out_ready): after the last element of a matrix the
// block drains its S column sums in column order, one per cycle while the
// receiver is ready, with last_column set on the final one. The last product is
// registered, then added into the ring of accumulators, and the first sum is
// then loaded into the output register.
// A matrix of size S takes S*S input transfers; while it drains, input is held
// off. The sums come from a ring of accumulator cells rotating through the
// single head adder.
// If the receiver stalls, the output register holds its sum and the drain
// pauses; sums are never lost.
// Configuration (cfg_valid/cfg_ready, matrix_size) is always ready; a write sets
// the size (0 reads as 1, above MAX_SIZE as MAX_SIZE) and starts a fresh matrix.
// Reset sets the size to 64 (bounded by MAX_SIZE), zeroes every accumulator and
// the column, row and drain counters.
module transposed_matrix_vector_multiply
  import tmv_pkg::*;
#(
  parameter int MAX_SIZE = DEFAULT_MAX_SIZE
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_W-1:0]          matrix_size,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [DATA_W-1:0]  matrix_value,
  input  logic signed [DATA_W-1:0]  vector_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [INDEX_W-1:0]        column_index,
  output logic signed [DATA_W-1:0]  column_sum,
  output logic                      last_column
);

  localparam int SIZE_W = $clog2(MAX_SIZE + 1);
  localparam int IDX_W  = $clog2(MAX_SIZE);
  localparam logic [SIZE_W-1:0] RESET_EFF =
    SIZE_W'((RESET_SIZE > MAX_SIZE) ? MAX_SIZE : RESET_SIZE);

  logic                cfg_fire;
  logic [SIZE_W-1:0]   size;
  logic [SIZE_W-1:0]   size_next;
  logic [DATA_W-1:0]   product;
  logic [DATA_W-1:0]   wrap_val;
  logic [DATA_W-1:0]   acc [MAX_SIZE];
  logic [IDX_W-1:0]    dump_idx;
  tmv_ring_ctl_t       ctl;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    if (matrix_size == '0) begin
      size_next = SIZE_W'(1);
    end else if (matrix_size > CFG_W'(MAX_SIZE)) begin
      size_next = SIZE_W'(MAX_SIZE);
    end else begin
      size_next = SIZE_W'(matrix_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= RESET_EFF;
    end else if (cfg_fire) begin
      size <= size_next;
    end
  end

  // Only the low word of the product is kept, so sums wrap modulo 2^32.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      product <= DATA_W'(matrix_value * vector_value);
    end
  end

  // The head cell always holds the current column; its updated sum re-enters
  // the ring at the tail. While draining, the tail refills with zero instead.
  assign wrap_val = ctl.dump ? '0 : acc[0] + product;

  tmv_ctrl #(
    .MAX_SIZE (MAX_SIZE),
    .SIZE_W   (SIZE_W),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_fire  (cfg_fire),
    .size      (size),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .ctl       (ctl),
    .dump_idx  (dump_idx)
  );

  for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
    localparam logic [SIZE_W-1:0] POS = SIZE_W'(k + 1);
    logic [DATA_W-1:0] from_next;

    if (k == MAX_SIZE - 1) begin : g_end
      assign from_next = '0;
    end else begin : g_mid
      assign from_next = acc[k+1];
    end

    tmv_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .is_tail   (POS == size),
      .from_next (from_next),
      .wrap_in   (wrap_val),
      .acc       (acc[k])
    );
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      column_index <= INDEX_W'(dump_idx);
      column_sum   <= acc[0];
      last_column  <= ctl.last_out;
    end
  end

endmodule

@@ bench/column_sum_checker.sv @@
`timescale 1ns / 100ps

module column_sum_checker
  import tmv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_W-1:0]         matrix_size,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [DATA_W-1:0] matrix_value,
  input  logic signed [DATA_W-1:0] vector_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [INDEX_W-1:0]       column_index,
  input  logic signed [DATA_W-1:0] column_sum,
  input  logic                     last_column,
  output int                       mismatches,
  output int                       sums_pending
);

  localparam int MAX_COLUMNS = DEFAULT_MAX_SIZE;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  sum;
    logic               last;
  } column_result_t;

  logic [DATA_W-1:0]  column_acc [MAX_COLUMNS];
  logic [INDEX_W-1:0] row_pos;
  logic [INDEX_W-1:0] col_pos;
  logic [CFG_W-1:0]   size_setting;
  column_result_t     expected_sums [$];
  int                 fail_count = 0;

  // A size of zero behaves as one, anything above the accumulator count as the maximum.
  function automatic int unsigned active_size();
    if (size_setting == '0) return 1;
    if (size_setting > MAX_COLUMNS) return MAX_COLUMNS;
    return 32'(size_setting);
  endfunction

  task automatic clear_matrix();
    for (int k = 0; k < MAX_COLUMNS; k++) column_acc[k] = '0;
    row_pos = '0;
    col_pos = '0;
  endtask

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_LIMIT) $display("%0t ns: column sum check: %s", $time, what);
    fail_count++;
  endtask

  task automatic accumulate(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] product;
    int unsigned       n;
    int unsigned       col;
    column_result_t    sum_out;
    n = active_size();
    col = 32'(col_pos);
    if (col >= n) col = n - 1;
    // Only the low word of the product counts, so an unsigned multiply gives the same bits.
    product = a * b;
    column_acc[col] = column_acc[col] + product;
    if (col + 1 >= n) begin
      col_pos = '0;
      if (row_pos + 1 >= n) begin
        for (int k = 0; k < n; k++) begin
          sum_out.index = INDEX_W'(k);
          sum_out.sum   = column_acc[k];
          sum_out.last  = (k + 1 == n);
          expected_sums.push_back(sum_out);
        end
        clear_matrix();
      end else begin
        row_pos = row_pos + INDEX_W'(1);
      end
    end else begin
      col_pos = INDEX_W'(col + 1);
    end
  endtask

  task automatic check_sum();
    column_result_t want;
    if (expected_sums.size() == 0) begin
      report_mismatch($sformatf("sum %0d for column %0d with none outstanding",
                                column_sum, column_index));
      return;
    end
    want = expected_sums.pop_front();
    if (column_index !== want.index)
      report_mismatch($sformatf("column_index %0d, wanted %0d", column_index, want.index));
    if (column_sum !== want.sum)
      report_mismatch($sformatf("column %0d: column_sum %0d, wanted %0d",
                                want.index, column_sum, $signed(want.sum)));
    if (last_column !== want.last)
      report_mismatch($sformatf("column %0d: last_column %b, wanted %b",
                                want.index, last_column, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      size_setting = CFG_W'(RESET_SIZE);
      clear_matrix();
      expected_sums.delete();
    end else begin
      if (out_valid && out_ready) check_sum();
      if (cfg_valid && cfg_ready) begin
        size_setting = matrix_size;
        clear_matrix();
      end
      if (in_valid && in_ready) accumulate(matrix_value, vector_value);
    end
    mismatches   <= fail_count;
    sums_pending <= expected_sums.size();
  end

endmodule

@@ bench/transposed_matrix_vector_multiply_test.sv @@
`timescale 1ns / 100ps

module transposed_matrix_vector_multiply_test;
  import tmv_pkg::*;

  localparam int RANDOM_ITEMS  = 100;
  localparam int PARTIAL_ITEMS = 8;
  localparam int SETTLE        = 8;
  localparam int LONG_HOLD     = 300;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         matrix_size;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] matrix_value;
  logic signed [DATA_W-1:0] vector_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [INDEX_W-1:0]       column_index;
  logic signed [DATA_W-1:0] column_sum;
  logic                     last_column;
  int                       mismatches;
  int                       sums_pending;

  bit steady_tx  = 1'b0;
  bit hold_armed = 1'b0;

  transposed_matrix_vector_multiply dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .matrix_size  (matrix_size),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .matrix_value (matrix_value),
    .vector_value (vector_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .column_index (column_index),
    .column_sum   (column_sum),
    .last_column  (last_column)
  );

  column_sum_checker checker_inst (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .matrix_size  (matrix_size),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .matrix_value (matrix_value),
    .vector_value (vector_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .column_index (column_index),
    .column_sum   (column_sum),
    .last_column  (last_column),
    .mismatches   (mismatches),
    .sums_pending (sums_pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #8ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DATA_W-1:0] data_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4, 5, 6: return $urandom;
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  function automatic int unsigned rows_for(input logic [CFG_W-1:0] s);
    if (s == '0) return 1;
    if (s > DEFAULT_MAX_SIZE) return DEFAULT_MAX_SIZE;
    return 32'(s);
  endfunction

  function automatic logic [CFG_W-1:0] pick_size();
    if ($urandom_range(0, 9) == 0) return '0;
    return CFG_W'($urandom_range(1, 8));
  endfunction

  task automatic write_size(input logic [CFG_W-1:0] value);
    cfg_valid   <= 1'b1;
    matrix_size <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Valid is left high after a transfer; the next call lowers it only if it idles.
  task automatic send_item(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] v);
    int gap;
    gap = steady_tx ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    matrix_value <= m;
    vector_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_elements(input int unsigned count);
    repeat (count) send_item(data_word(), data_word());
  endtask

  // The checker's count is registered, hence the wait for an edge before the first look.
  task automatic wait_for_sums(input int quiet);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  initial begin : receiver
    int gap;
    int seen;
    bit steady;
    bit hold_done;
    seen      = 0;
    steady    = 1'b0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      seen++;
      if (seen % 50 == 0) steady = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : stimulus
    int               random_items;
    int               phase;
    int unsigned      n;
    int unsigned      count;
    int               matrices;
    logic [CFG_W-1:0] size;
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    matrix_size  <= '0;
    in_valid     <= 1'b0;
    matrix_value <= '0;
    vector_value <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // A few elements at the size left by reset; the next size write discards them.
    send_elements(PARTIAL_ITEMS);
    wait_for_sums(SETTLE);

    // Single-element matrices: every product lands straight in a result.
    write_size(7'd1);
    send_item(32'h8000_0000, 32'h8000_0000);
    send_item(32'h7fff_ffff, 32'h7fff_ffff);
    send_item(32'hffff_ffff, 32'hffff_ffff);
    send_item(32'h8000_0000, 32'hffff_ffff);
    send_item(32'h7fff_ffff, 32'h8000_0000);
    send_item(32'h0000_0000, 32'h7fff_ffff);
    wait_for_sums(SETTLE);

    write_size(7'd0);
    send_item(32'h1234_5678, 32'hffff_fffe);
    send_item(32'h8000_0001, 32'h0000_0003);
    wait_for_sums(SETTLE);

    // Column sums that overflow and wrap.
    write_size(7'd2);
    send_item(32'h7fff_ffff, 32'h0000_0002);
    send_item(32'h8000_0000, 32'h7fff_ffff);
    send_item(32'h7fff_ffff, 32'h0000_0002);
    send_item(32'h8000_0000, 32'h0000_0001);
    wait_for_sums(SETTLE);

    // A size write part-way through a matrix throws the partial sums away.
    write_size(7'd3);
    send_elements(4);
    wait_for_sums(SETTLE);
    write_size(7'd3);
    send_elements(9);
    wait_for_sums(SETTLE);

    // An oversized setting behaves as the largest matrix; these sums are discarded too.
    steady_tx = 1'b1;
    write_size(7'd127);
    send_elements(PARTIAL_ITEMS);
    wait_for_sums(SETTLE);

    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      size      = (phase == 0) ? 7'd6 : pick_size();
      n         = rows_for(size);
      steady_tx = ($urandom_range(0, 3) == 0);
      write_size(size);
      // The receiver's long stall lands in the first drain of this phase, while the
      // second matrix is already being offered, so the input stalls behind it.
      if (phase == 0) hold_armed = 1'b1;
      matrices = (phase == 0) ? 2 : $urandom_range(1, 3);
      for (int k = 0; k < matrices; k++) begin
        if (phase != 0 && random_items >= RANDOM_ITEMS) break;
        if (phase != 0 && n > 1 && $urandom_range(0, 5) == 0) begin
          count = $urandom_range(1, n * n - 1);
          send_elements(count);
          random_items += count;
          break;
        end
        send_elements(n * n);
        random_items += n * n;
        if (phase != 0 && $urandom_range(0, 3) == 0) wait_for_sums(0);
      end
      wait_for_sums(SETTLE);
      phase++;
    end

    wait_for_sums(20);
    if (mismatches == 0 && sums_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/tmv_pkg.sv
design/tmv_cell.sv
design/tmv_ctrl.sv
design/transposed_matrix_vector_multiply.sv
bench/column_sum_checker.sv
bench/transposed_matrix_vector_multiply_test.sv
